// ===== sv/fisr_pkg.sv =====
// Shared types, constants and binary32 arithmetic helpers for the inverse square root block.
package fisr_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
	localparam logic [31:0] HALF_BITS = 32'h3f000000;
	localparam logic [31:0] THREE_BITS = 32'h40400000;
	localparam logic [31:0] CANON_NAN = 32'h7fc00000;
	localparam logic [7:0] EXP_MAX = 8'hff;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} fisr_item_t;

	typedef struct packed {
		logic sign;
		logic nan;
		logic inf;
		logic signed [11:0] e;
		logic [47:0] prod;
	} fisr_mul_t;

	typedef struct packed {
		logic sign;
		logic nan;
		logic inf;
		logic zsign;
		logic [7:0] e;
		logic [27:0] sum;
	} fisr_add_t;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic found;
		n = '0;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) found = 1'b1;
				else n = n + 6'd1;
			end
		end
		return n;
	endfunction

	function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] e,
			input logic [47:0] n);
		logic signed [11:0] sh;
		logic [47:0] nsh;
		logic stk;
		logic [10:0] ebase;
		logic inc;
		logic [34:0] packed_v;
		nsh = n;
		stk = 1'b0;
		ebase = '0;
		if (n == '0) return {sign, 31'b0};
		if (e < 12'sd1) begin
			sh = 12'sd1 - e;
			if (sh > 12'sd47) begin
				nsh = '0;
				stk = 1'b1;
			end else begin
				nsh = n >> sh[5:0];
				stk = ((nsh << sh[5:0]) != n);
			end
		end else begin
			sh = e - 12'sd1;
			ebase = sh[10:0];
		end
		inc = nsh[23] & ((|nsh[22:0]) | stk | nsh[24]);
		packed_v = {1'b0, ebase, 23'b0} + {11'b0, nsh[47:24]} + {34'b0, inc};
		if (packed_v[34:23] >= 12'd255) return {sign, EXP_MAX, 23'b0};
		return {sign, packed_v[30:0]};
	endfunction

	function automatic fisr_mul_t mul_pre(input logic [31:0] a, input logic [31:0] b);
		fisr_mul_t r;
		logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [7:0] eae, ebe;
		logic [23:0] ma, mb;
		a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != '0);
		b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != '0);
		a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == '0);
		b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == '0);
		a_zero = (a[30:0] == '0);
		b_zero = (b[30:0] == '0);
		eae = (a[30:23] == '0) ? 8'd1 : a[30:23];
		ebe = (b[30:23] == '0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != '0, a[22:0]};
		mb = {b[30:23] != '0, b[22:0]};
		r.sign = a[31] ^ b[31];
		r.nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		r.inf = a_inf | b_inf;
		r.e = $signed({4'b0, eae}) + $signed({4'b0, ebe}) - 12'sd173;
		r.prod = {24'b0, ma} * {24'b0, mb};
		return r;
	endfunction

	function automatic logic [31:0] mul_post(input fisr_mul_t m);
		logic [5:0] lz;
		logic signed [11:0] e;
		lz = lzc48(m.prod);
		e = m.e + 12'sd47 - $signed({6'b0, lz});
		if (m.nan) return CANON_NAN;
		if (m.inf) return {m.sign, EXP_MAX, 23'b0};
		return round_pack(m.sign, e, m.prod << lz);
	endfunction

	function automatic fisr_add_t add_pre(input logic [31:0] a, input logic [31:0] b);
		fisr_add_t r;
		logic a_nan, b_nan, a_inf, b_inf, a_big;
		logic [7:0] eae, ebe, ebig, esml, d;
		logic [23:0] ma, mb;
		logic [26:0] big, sml, sft;
		a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != '0);
		b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != '0);
		a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == '0);
		b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == '0);
		eae = (a[30:23] == '0) ? 8'd1 : a[30:23];
		ebe = (b[30:23] == '0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != '0, a[22:0]};
		mb = {b[30:23] != '0, b[22:0]};
		a_big = (eae > ebe) || ((eae == ebe) && (ma >= mb));
		ebig = a_big ? eae : ebe;
		esml = a_big ? ebe : eae;
		big = a_big ? {ma, 3'b0} : {mb, 3'b0};
		sml = a_big ? {mb, 3'b0} : {ma, 3'b0};
		d = ebig - esml;
		if (d > 8'd26) sft = {26'b0, sml != '0};
		else sft = (sml >> d[4:0]) | {26'b0, ((sml >> d[4:0]) << d[4:0]) != sml};
		r.nan = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
		r.inf = a_inf | b_inf;
		r.sign = a_inf ? a[31] : (b_inf ? b[31] : (a_big ? a[31] : b[31]));
		r.zsign = a[31] & b[31];
		r.e = ebig;
		if (a[31] ^ b[31]) r.sum = {1'b0, big} - {1'b0, sft};
		else r.sum = {1'b0, big} + {1'b0, sft};
		return r;
	endfunction

	function automatic logic [31:0] add_post(input fisr_add_t s);
		logic [5:0] lz;
		logic signed [11:0] e;
		lz = lzc48({s.sum, 20'b0});
		e = $signed({4'b0, s.e}) + 12'sd1 - $signed({6'b0, lz});
		if (s.nan) return CANON_NAN;
		if (s.inf) return {s.sign, EXP_MAX, 23'b0};
		if (s.sum == '0) return {s.zsign, 31'b0};
		return round_pack(s.sign, e, {s.sum, 20'b0} << lz);
	endfunction

endpackage

// ===== sv/fisr_front.sv =====
// Front stage: takes operand beats and forms the integer initial guess.
module fisr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] operand_bits,
	output logic q_valid,
	input logic q_stall,
	output fisr_pkg::fisr_item_t q_item
);
	import fisr_pkg::*;

	logic vld_s1;
	fisr_item_t item_s1;
	logic [31:0] shifted;

	assign shifted = {operand_bits[31], operand_bits[31:1]};
	assign in_stall = vld_s1 && q_stall;
	assign q_valid = vld_s1;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.x <= operand_bits;
			item_s1.y <= MAGIC_GUESS - shifted;
		end
	end
endmodule

// ===== sv/fisr_queue.sv =====
// Small register queue between the front and back parts.
module fisr_queue #(
	parameter int DEPTH = fisr_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fisr_pkg::fisr_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output fisr_pkg::fisr_item_t out_item
);
	import fisr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fisr_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item = mem_q[rd_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end
endmodule

// ===== sv/fisr_back.sv =====
// Back pipeline: one Newton step in binary32 with round to nearest even.
module fisr_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fisr_pkg::fisr_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] approx_bits
);
	import fisr_pkg::*;

	logic [7:0] vld_q;
	logic adv;
	fisr_mul_t mb_s1, ma_s1, mc_s3, mr_s7;
	fisr_add_t ad_s5;
	logic [31:0] y_s1, y_s2, b_s2, a_s2, a_s3, c_s4, a_s4, a_s5, d_s6, a_s6, r_s8;

	assign adv = !(vld_q[7] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[7];
	assign approx_bits = r_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mb_s1 <= mul_pre(in_item.x, in_item.y);
			ma_s1 <= mul_pre(HALF_BITS, in_item.y);
			y_s1 <= in_item.y;
			b_s2 <= mul_post(mb_s1);
			a_s2 <= mul_post(ma_s1);
			y_s2 <= y_s1;
			mc_s3 <= mul_pre(b_s2, y_s2);
			a_s3 <= a_s2;
			c_s4 <= mul_post(mc_s3);
			a_s4 <= a_s3;
			ad_s5 <= add_pre(THREE_BITS, {~c_s4[31], c_s4[30:0]});
			a_s5 <= a_s4;
			d_s6 <= add_post(ad_s5);
			a_s6 <= a_s5;
			mr_s7 <= mul_pre(a_s6, d_s6);
			r_s8 <= mul_post(mr_s7);
		end
	end
endmodule

// ===== sv/fast_inverse_sqrt.sv =====
// Fast inverse square root with one Newton step, top level.
// The input channel (in_valid, in_stall, operand_bits) takes one binary32 pattern per beat.
// The output channel (out_valid, out_stall, approx_bits) gives one binary32 result per beat,
// in input order. A beat moves when valid is high and stall is low at a rising clock edge.
// Throughput is one beat per cycle while out_stall is low. A result passes from its operand
// through the front register, which forms the integer guess, then the queue and then the
// back pipeline, whose depth is set by the three chained multiplies and one add, each split
// into a product or sum stage and a normalize-round stage.
// While out_stall is high with a result on out_valid, the back pipeline holds and the result
// stays on approx_bits; the queue keeps taking beats until it is full, then in_stall rises.
// NaN results are returned as the quiet NaN 0x7FC00000.
// The asynchronous reset arst_n empties the pipeline and the queue; results in flight are lost
// and none are invented across it, and beats may be sent as soon as it is released.
module fast_inverse_sqrt #(
	parameter int QUEUE_DEPTH = fisr_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] operand_bits,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] approx_bits
);
	import fisr_pkg::*;

	logic fq_valid, fq_stall, qb_valid, qb_stall;
	fisr_item_t fq_item, qb_item;

	fisr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operand_bits(operand_bits),
		.q_valid(fq_valid), .q_stall(fq_stall), .q_item(fq_item)
	);

	fisr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fq_valid), .in_stall(fq_stall), .in_item(fq_item),
		.out_valid(qb_valid), .out_stall(qb_stall), .out_item(qb_item)
	);

	fisr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(qb_valid), .in_stall(qb_stall), .in_item(qb_item),
		.out_valid(out_valid), .out_stall(out_stall), .approx_bits(approx_bits)
	);
endmodule

// ===== sv/fisr_checker.sv =====
// Port-level checker for the inverse square root block and its bind.
module fisr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [31:0] approx_bits
);
	import fisr_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(approx_bits)) else $error("stalled result changed");

	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && approx_bits[30:23] == EXP_MAX && approx_bits[22:0] != '0
		|-> approx_bits == CANON_NAN) else $error("NaN result is not canonical");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without output back pressure");
endmodule

bind fast_inverse_sqrt fisr_checker u_fisr_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .approx_bits(approx_bits)
);
